// ===== rtl/slog_pkg.sv =====
// Shared types, sizes and codes of the sample log ring with window statistics.
package slog_pkg;

    // Ring size and derived widths
    localparam int DEPTH    = 16;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);

    // Field widths
    localparam int STAMP_W  = 20;
    localparam int TEMP_W   = 8;
    localparam int LIGHT_W  = 2;
    localparam int LED_W    = 4;
    localparam int MEAN_T_W = 12;
    localparam int MEAN_L_W = 6;
    localparam int FRAC_W   = 4;

    // Window sums and the serial divider
    localparam int SUM_T_W  = $clog2(DEPTH * 255 + 1);
    localparam int SUM_L_W  = $clog2(DEPTH * 3 + 1);
    localparam int DVD_W    = SUM_T_W + FRAC_W;
    localparam int STEP_W   = $clog2(DVD_W);

    // Stream word widths
    localparam int IN_W     = 72;
    localparam int OUT_W    = 56;
    localparam int CMD_W    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THR = 2'd2;

    localparam logic [TEMP_W-1:0]  TEMP_THR_RST  = 8'd20;
    localparam logic [LIGHT_W-1:0] LIGHT_THR_RST = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOG   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_READ,
        ST_WALK,
        ST_DRAIN,
        ST_DIV_T,
        ST_DIV_L,
        ST_DONE
    } state_t;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic                 end_given;
        logic                 start_given;
        logic [STAMP_W-1:0]   range_end;
        logic [STAMP_W-1:0]   range_start;
        logic [LIGHT_W-1:0]   light;
        logic [TEMP_W-1:0]    temperature;
        logic [STAMP_W-1:0]   stamp;
    } item_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [MEAN_L_W-1:0]  mean_light;
        logic [LIGHT_W-1:0]   min_light;
        logic [LIGHT_W-1:0]   max_light;
        logic [MEAN_T_W-1:0]  mean_temp;
        logic [TEMP_W-1:0]    min_temp;
        logic [TEMP_W-1:0]    max_temp;
        logic                 light_alarm;
        logic                 temp_alarm;
        logic [LED_W-1:0]     led_bar;
        logic [LIGHT_W-1:0]   read_light;
        logic [TEMP_W-1:0]    read_temperature;
        logic                 ok;
    } result_t;

    // One stored record
    typedef struct packed {
        logic [STAMP_W-1:0]   stamp;
        logic [TEMP_W-1:0]    temperature;
        logic [LIGHT_W-1:0]   light;
    } rec_t;

    // Bar code for a light level
    function automatic logic [LED_W-1:0] led_code(input logic [LIGHT_W-1:0] level);
        logic [LED_W-1:0] code;
        case (level)
            2'd0:    code = 4'h1;
            2'd1:    code = 4'h3;
            2'd2:    code = 4'h7;
            default: code = 4'hf;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/sample_log_ring_with_window_stats_core.sv =====
// Top level of the sample log ring: record store, sequencer and shared divider.
//
//  channel   | direction | handshake              | content
//  ----------+-----------+------------------------+-----------------------------------
//  s_*       | in        | s_tvalid / s_tready    | command in tuser, item in tdata
//  m_*       | out       | m_tvalid / m_tready    | one result word per item
//  cfg_*     | in        | cfg_valid / cfg_ready  | register index and write data
//
// Every item is accepted in IDLE and handed off to the output register from DONE.
// Log runs LOG and read runs READ before DONE; a read with nothing unread skips READ.
// A query walks valid_count records, drains, then makes two passes of DVD_W (16) quotient
// bits through the one restoring divider (temperature mean, then light mean); an empty
// window skips the divider.
// Reset sets control state, pointers and configuration; the record memory is not cleared.
// A stalled m side holds its word; the next item runs meanwhile and waits in DONE.
module sample_log_ring_with_window_stats_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // stamp, temperature, light, range_start, range_end, start_given, end_given
    input  logic [slog_pkg::IN_W-1:0]       s_tdata,
    // command
    input  logic [slog_pkg::CMD_W-1:0]      s_tuser,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // ok, read_temperature, read_light, led_bar, temp_alarm, light_alarm, max_temp,
    // min_temp, mean_temp, max_light, min_light, mean_light, zero pad
    output logic [slog_pkg::OUT_W-1:0]      m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [slog_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slog_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W  = slog_pkg::ADDR_W;
    localparam int CNT_W   = slog_pkg::CNT_W;
    localparam int TEMP_W  = slog_pkg::TEMP_W;
    localparam int LIGHT_W = slog_pkg::LIGHT_W;
    localparam int SUM_T_W = slog_pkg::SUM_T_W;
    localparam int SUM_L_W = slog_pkg::SUM_L_W;
    localparam int DVD_W   = slog_pkg::DVD_W;
    localparam int STEP_W  = slog_pkg::STEP_W;

    // Sequencer
    slog_pkg::state_t state_reg, state_next;

    // Configuration
    logic                alarm_en_reg;
    logic [TEMP_W-1:0]   temp_thr_reg;
    logic [LIGHT_W-1:0]  light_thr_reg;

    // Item and pointers
    slog_pkg::item_t     item_reg, item_next;
    logic [CNT_W-1:0]    valid_count_reg, valid_count_next;
    logic [CNT_W-1:0]    unread_count_reg, unread_count_next;
    logic [ADDR_W-1:0]   write_ptr_reg, write_ptr_next;
    logic [ADDR_W-1:0]   read_ptr_reg, read_ptr_next;

    // Window walk and accumulators
    logic [ADDR_W-1:0]   walk_idx_reg, walk_idx_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SUM_T_W-1:0]  sum_t_reg, sum_t_next;
    logic [SUM_L_W-1:0]  sum_l_reg, sum_l_next;
    logic [TEMP_W-1:0]   max_t_reg, max_t_next;
    logic [TEMP_W-1:0]   min_t_reg, min_t_next;
    logic [LIGHT_W-1:0]  max_l_reg, max_l_next;
    logic [LIGHT_W-1:0]  min_l_reg, min_l_next;

    // Shared divider
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [DVD_W-1:0]    dvd_reg, dvd_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // Result and output register
    slog_pkg::result_t   res_reg, res_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [slog_pkg::OUT_W-1:0] m_tdata_reg, m_tdata_next;

    // Record memory
    slog_pkg::rec_t      mem [slog_pkg::DEPTH];
    slog_pkg::rec_t      rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                mem_we;

    // Combinational helpers
    logic                in_win;
    logic                acc_hit;
    logic [CNT_W-1:0]    cnt_acc;
    logic [SUM_T_W-1:0]  sum_t_acc;
    logic [SUM_L_W-1:0]  sum_l_acc;
    logic [TEMP_W-1:0]   max_t_acc, min_t_acc;
    logic [LIGHT_W-1:0]  max_l_acc, min_l_acc;
    logic [CNT_W:0]      div_shift;
    logic [CNT_W:0]      div_diff;
    logic                div_ge;
    logic [CNT_W-1:0]    div_rem;
    logic [DVD_W-1:0]    div_quo;
    logic                div_last;
    logic                walk_last;
    logic                out_free;

    assign s_tready  = (state_reg == slog_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Walk the ring by index, otherwise point at the oldest unread record
    assign rd_addr   = (state_reg == slog_pkg::ST_WALK) ? walk_idx_reg : read_ptr_reg;
    assign walk_last = (walk_idx_reg == ADDR_W'(valid_count_reg - CNT_W'(1)));

    // Window test and accumulate on the record fetched last cycle
    assign in_win  = (!item_reg.start_given || (rd_data_reg.stamp >= item_reg.range_start))
                  && (!item_reg.end_given || (rd_data_reg.stamp <= item_reg.range_end));
    assign acc_hit = pend_reg && in_win;

    always_comb
    begin
        cnt_acc   = cnt_reg;
        sum_t_acc = sum_t_reg;
        sum_l_acc = sum_l_reg;
        max_t_acc = max_t_reg;
        min_t_acc = min_t_reg;
        max_l_acc = max_l_reg;
        min_l_acc = min_l_reg;
        if (acc_hit)
        begin
            cnt_acc   = cnt_reg + CNT_W'(1);
            sum_t_acc = sum_t_reg + SUM_T_W'(rd_data_reg.temperature);
            sum_l_acc = sum_l_reg + SUM_L_W'(rd_data_reg.light);
            if (rd_data_reg.temperature > max_t_reg) max_t_acc = rd_data_reg.temperature;
            if (rd_data_reg.temperature < min_t_reg) min_t_acc = rd_data_reg.temperature;
            if (rd_data_reg.light > max_l_reg)       max_l_acc = rd_data_reg.light;
            if (rd_data_reg.light < min_l_reg)       min_l_acc = rd_data_reg.light;
        end
    end

    // One restoring divide step: remainder shift, compare, subtract
    assign div_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign div_diff  = div_shift - {1'b0, cnt_reg};
    assign div_ge    = (div_shift >= {1'b0, cnt_reg});
    assign div_rem   = div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
    assign div_quo   = {dvd_reg[DVD_W-2:0], div_ge};
    assign div_last  = (step_reg == STEP_W'(DVD_W - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slog_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        slog_pkg::CMD_LOG:
                            state_next = slog_pkg::ST_LOG;
                        slog_pkg::CMD_READ:
                            state_next = (unread_count_reg != '0) ? slog_pkg::ST_READ
                                                                  : slog_pkg::ST_DONE;
                        slog_pkg::CMD_QUERY:
                            state_next = (valid_count_reg != '0) ? slog_pkg::ST_WALK
                                                                 : slog_pkg::ST_DONE;
                        default:
                            state_next = slog_pkg::ST_DONE;
                    endcase
                end
            end
            slog_pkg::ST_LOG:   state_next = slog_pkg::ST_DONE;
            slog_pkg::ST_READ:  state_next = slog_pkg::ST_DONE;
            slog_pkg::ST_WALK:  state_next = walk_last ? slog_pkg::ST_DRAIN : slog_pkg::ST_WALK;
            slog_pkg::ST_DRAIN: state_next = (cnt_acc == '0) ? slog_pkg::ST_DONE
                                                             : slog_pkg::ST_DIV_T;
            slog_pkg::ST_DIV_T: state_next = div_last ? slog_pkg::ST_DIV_L : slog_pkg::ST_DIV_T;
            slog_pkg::ST_DIV_L: state_next = div_last ? slog_pkg::ST_DONE : slog_pkg::ST_DIV_L;
            slog_pkg::ST_DONE:  state_next = out_free ? slog_pkg::ST_IDLE : slog_pkg::ST_DONE;
            default:            state_next = slog_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb
    begin
        item_next         = item_reg;
        valid_count_next  = valid_count_reg;
        unread_count_next = unread_count_reg;
        write_ptr_next    = write_ptr_reg;
        read_ptr_next     = read_ptr_reg;
        walk_idx_next     = walk_idx_reg;
        pend_next         = 1'b0;
        cnt_next          = cnt_acc;
        sum_t_next        = sum_t_acc;
        sum_l_next        = sum_l_acc;
        max_t_next        = max_t_acc;
        min_t_next        = min_t_acc;
        max_l_next        = max_l_acc;
        min_l_next        = min_l_acc;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        step_next         = step_reg;
        res_next          = res_reg;
        mem_we            = 1'b0;
        m_tvalid_next     = m_tvalid_reg && !m_tready;
        m_tdata_next      = m_tdata_reg;

        case (state_reg)
            slog_pkg::ST_IDLE:
            begin
                // Take the item and clear the window statistics
                if (s_tvalid)
                begin
                    item_next     = slog_pkg::item_t'(s_tdata);
                    res_next      = '0;
                    walk_idx_next = '0;
                    cnt_next      = '0;
                    sum_t_next    = '0;
                    sum_l_next    = '0;
                    max_t_next    = '0;
                    min_t_next    = '1;
                    max_l_next    = '0;
                    min_l_next    = '1;
                end
            end
            slog_pkg::ST_LOG:
            begin
                // Store the record, overwrite the oldest when full
                mem_we         = 1'b1;
                write_ptr_next = (write_ptr_reg == ADDR_W'(slog_pkg::DEPTH - 1))
                               ? '0 : write_ptr_reg + ADDR_W'(1);
                if (valid_count_reg < CNT_W'(slog_pkg::DEPTH))
                    valid_count_next = valid_count_reg + CNT_W'(1);
                if (unread_count_reg >= CNT_W'(slog_pkg::DEPTH))
                    read_ptr_next = (read_ptr_reg == ADDR_W'(slog_pkg::DEPTH - 1))
                                  ? '0 : read_ptr_reg + ADDR_W'(1);
                else
                    unread_count_next = unread_count_reg + CNT_W'(1);
                if (alarm_en_reg)
                begin
                    res_next.temp_alarm  = (item_reg.temperature >= temp_thr_reg);
                    res_next.light_alarm = (item_reg.light >= light_thr_reg);
                end
            end
            slog_pkg::ST_READ:
            begin
                // Return the oldest unread record and advance
                res_next.ok               = 1'b1;
                res_next.read_temperature = rd_data_reg.temperature;
                res_next.read_light       = rd_data_reg.light;
                res_next.led_bar          = slog_pkg::led_code(rd_data_reg.light);
                read_ptr_next = (read_ptr_reg == ADDR_W'(slog_pkg::DEPTH - 1))
                              ? '0 : read_ptr_reg + ADDR_W'(1);
                unread_count_next = unread_count_reg - CNT_W'(1);
            end
            slog_pkg::ST_WALK:
            begin
                pend_next     = 1'b1;
                walk_idx_next = walk_idx_reg + ADDR_W'(1);
            end
            slog_pkg::ST_DRAIN:
            begin
                // Load the temperature sum, scaled to Q.4
                rem_next  = '0;
                step_next = '0;
                dvd_next  = {sum_t_acc, slog_pkg::FRAC_W'(0)};
            end
            slog_pkg::ST_DIV_T:
            begin
                rem_next  = div_rem;
                dvd_next  = div_quo;
                step_next = step_reg + STEP_W'(1);
                if (div_last)
                begin
                    res_next.mean_temp = div_quo[slog_pkg::MEAN_T_W-1:0];
                    rem_next  = '0;
                    step_next = '0;
                    dvd_next  = DVD_W'({sum_l_reg, slog_pkg::FRAC_W'(0)});
                end
            end
            slog_pkg::ST_DIV_L:
            begin
                rem_next  = div_rem;
                dvd_next  = div_quo;
                step_next = step_reg + STEP_W'(1);
                if (div_last)
                begin
                    res_next.ok         = 1'b1;
                    res_next.mean_light = div_quo[slog_pkg::MEAN_L_W-1:0];
                    res_next.max_temp   = max_t_reg;
                    res_next.min_temp   = min_t_reg;
                    res_next.max_light  = max_l_reg;
                    res_next.min_light  = min_l_reg;
                    step_next = '0;
                end
            end
            slog_pkg::ST_DONE:
            begin
                // Hand the word to the output register once it is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = slog_pkg::OUT_W'(res_reg);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    // Control and pointer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= slog_pkg::ST_IDLE;
            valid_count_reg  <= '0;
            unread_count_reg <= '0;
            write_ptr_reg    <= '0;
            read_ptr_reg     <= '0;
            pend_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            valid_count_reg  <= valid_count_next;
            unread_count_reg <= unread_count_next;
            write_ptr_reg    <= write_ptr_next;
            read_ptr_reg     <= read_ptr_next;
            pend_reg         <= pend_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        walk_idx_reg <= walk_idx_next;
        cnt_reg      <= cnt_next;
        sum_t_reg    <= sum_t_next;
        sum_l_reg    <= sum_l_next;
        max_t_reg    <= max_t_next;
        min_t_reg    <= min_t_next;
        max_l_reg    <= max_l_next;
        min_l_reg    <= min_l_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_en_reg  <= 1'b0;
            temp_thr_reg  <= slog_pkg::TEMP_THR_RST;
            light_thr_reg <= slog_pkg::LIGHT_THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                slog_pkg::CFG_ALARM_EN:  alarm_en_reg  <= cfg_data[0];
                slog_pkg::CFG_TEMP_THR:  temp_thr_reg  <= cfg_data[TEMP_W-1:0];
                slog_pkg::CFG_LIGHT_THR: light_thr_reg <= cfg_data[LIGHT_W-1:0];
                default:                 alarm_en_reg  <= alarm_en_reg;
            endcase
        end
    end

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[write_ptr_reg] <= '{stamp:       item_reg.stamp,
                                    temperature: item_reg.temperature,
                                    light:       item_reg.light};
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTH
    // Unread records are always a subset of the valid ones
    a_unread_le_valid: assert property (@(posedge clk) disable iff (!rst_n)
        unread_count_reg <= valid_count_reg)
        else $error("unread count exceeds valid count");

    // The walk never passes the filled part of the ring
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slog_pkg::ST_WALK |-> CNT_W'(walk_idx_reg) < valid_count_reg)
        else $error("walk index beyond valid records");

    // An accepted item always leaves the idle state
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != slog_pkg::ST_IDLE)
        else $error("item accepted without starting work");

    // A query result with records never has min above max
    a_query_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == slog_pkg::ST_DIV_L && div_last |=>
            res_reg.min_temp <= res_reg.max_temp && res_reg.min_light <= res_reg.max_light)
        else $error("window min above max");
`endif

endmodule
